>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pltr_pkg.sv
`timescale 1ns / 1ps

package pltr_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = 48;
  localparam int STAMP_W       = 64;
  localparam int SLOT_W        = 3;

  // Reported outcome codes.
  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_REPLACE = 2'd2
  } outcome_t;

  // Search token that walks down the chain of cells, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
    logic               old;
    logic [IDX_W-1:0]   old_idx;
    logic [STAMP_W-1:0] old_stamp;
    logic [ADDR_W-1:0]  old_addr;
  } cell_tok_t;

  // Write broadcast from the controller to all cells.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]  addr;
    logic [STAMP_W-1:0] stamp;
  } cell_wr_t;

endpackage

>>> rtl/peer_table_lru_replace.sv
`timescale 1ns / 1ps
// A request is captured and a search token walks the chain of entry cells one cell per
// cycle; the finished token is held and committed to the output register, where a stall
// can hold it. A new request is not accepted until the previous one has been committed.
// Reset: synchronous, active high; clears all entry valid bits, the search tokens, the output
// valid and the control state. Addresses and times are not cleared and are never read unset.
`include "assert_macros.svh"

module peer_table_lru_replace import pltr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ADDR_W-1:0]  peer_address,
  input  logic [STAMP_W-1:0] time_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         outcome,
  output logic [SLOT_W-1:0]  slot_index,
  output logic [ADDR_W-1:0]  evicted_address
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  req_addr;
  logic [STAMP_W-1:0] req_time;
  cell_tok_t          fin;
  cell_tok_t          chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0]   tok_vld;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  cell_wr_t           wr;
  logic               accept;
  logic               can_load;
  logic               commit_go;
  logic [IDX_W-1:0]   target_idx;
  logic [IDX_W+2:0]   slot_wide;
  outcome_t           code;
  logic [ADDR_W-1:0]  evicted;
  outcome_t           out_code;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid || !out_stall;
  assign commit_go = (state == ST_COMMIT) && can_load;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_addr <= peer_address;
      req_time <= time_now;
    end
  end

  // Inject a fresh token into the head of the chain.
  always_comb begin
    chain[0]     = '0;
    chain[0].vld = (state == ST_LAUNCH);
  end

  // Chain of entry cells.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pltr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .slot_id     (IDX_W'(g)),
      .req_addr    (req_addr),
      .tok_in      (chain[g]),
      .wr          (wr),
      .tok_out     (chain[g+1]),
      .entry_valid (entry_valid[g])
    );
  end

  for (genvar t = 0; t <= TABLE_ENTRIES; t++) begin : g_vld
    assign tok_vld[t] = chain[t].vld;
  end

  // Hold the finished token until it is committed.
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && chain[TABLE_ENTRIES].vld) begin
      fin <= chain[TABLE_ENTRIES];
    end
  end

  // Decide the outcome from the finished token.
  always_comb begin
    if (fin.hit) begin
      code       = OUT_HIT;
      target_idx = fin.hit_idx;
      evicted    = '0;
    end else if (fin.free) begin
      code       = OUT_FILL;
      target_idx = fin.free_idx;
      evicted    = '0;
    end else begin
      code       = OUT_REPLACE;
      target_idx = fin.old_idx;
      evicted    = fin.old_addr;
    end
  end

  assign slot_wide = {3'b000, target_idx};

  // Write broadcast to the chosen cell.
  always_comb begin
    wr.en    = commit_go;
    wr.idx   = target_idx;
    wr.addr  = req_addr;
    wr.stamp = req_time;
  end

  // Controller.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (chain[TABLE_ENTRIES].vld) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (can_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_code        <= code;
      slot_index      <= slot_wide[2:0];
      evicted_address <= evicted;
    end
  end

  assign outcome = out_code;

  `ASSERT_ALWAYS(a_single_token, $onehot0(tok_vld), "more than one search token in the chain")
  `ASSERT_IMPLIES(a_replace_full, (state == ST_COMMIT) && !fin.hit && !fin.free, (&entry_valid), "replace with a free entry present")
  `ASSERT_IMPLIES(a_hit_no_evict, out_valid && (out_code != OUT_REPLACE), (evicted_address == '0), "evicted address set without replace")
  `ASSERT_NEXT(a_commit_shows, commit_go, out_valid, "committed request not shown at output")

endmodule

>>> rtl/pltr_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pltr_cell import pltr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  slot_id,
  input  logic [ADDR_W-1:0] req_addr,
  input  cell_tok_t         tok_in,
  input  cell_wr_t          wr,
  output cell_tok_t         tok_out,
  output logic              entry_valid
);

  logic               valid;
  logic [ADDR_W-1:0]  addr;
  logic [STAMP_W-1:0] last_use;
  cell_tok_t          tok_next;
  logic               wr_here;

  assign entry_valid = valid;
  assign wr_here     = wr.en && (wr.idx == slot_id);

  // Fold this entry into the passing token: first hit, first free slot, and
  // the oldest valid entry with ties kept at the lower index.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld) begin
      if (!tok_in.hit && valid && (addr == req_addr)) begin
        tok_next.hit     = 1'b1;
        tok_next.hit_idx = slot_id;
      end
      if (!tok_in.free && !valid) begin
        tok_next.free     = 1'b1;
        tok_next.free_idx = slot_id;
      end
      if (valid && (!tok_in.old || (last_use < tok_in.old_stamp))) begin
        tok_next.old       = 1'b1;
        tok_next.old_idx   = slot_id;
        tok_next.old_stamp = last_use;
        tok_next.old_addr  = addr;
      end
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Entry storage; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      addr     <= wr.addr;
      last_use <= wr.stamp;
    end
  end

  `ASSERT_NEXT(a_cell_write_sets_valid, wr_here, valid, "cell not valid after write")

endmodule
